// ----- rtl/swbc_pkg.sv -----
// Shared types and constants of the sector write-back cache tag engine.
// No dependencies; used by the top level, the tag RAM users and the checker.
package swbc_pkg;

  localparam int SLOTS   = 32;
  localparam int RUN_MAX = 16;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int RUN_IW = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
  localparam int RLEN_W = $clog2(RUN_MAX + 1);
  localparam int ADDR_W = 32;
  localparam int SEQ_W  = 32;

  localparam logic [2:0] FUNC_WRITE      = 3'd0;
  localparam logic [2:0] FUNC_READ       = 3'd1;
  localparam logic [2:0] FUNC_FLUSH_SEL  = 3'd2;
  localparam logic [2:0] FUNC_FLUSH_DONE = 3'd3;
  localparam logic [2:0] FUNC_INVAL_ALL  = 3'd4;

  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_REFUSED = 3'd1;
  localparam logic [2:0] STATUS_FULL    = 3'd2;
  localparam logic [2:0] STATUS_NODIRTY = 3'd3;
  localparam logic [2:0] STATUS_DIRECT  = 3'd4;

  localparam logic [1:0] POLICY_WB = 2'd0;
  localparam logic [1:0] POLICY_WT = 2'd1;

  typedef struct packed {
    logic [2:0]        func;
    logic [ADDR_W-1:0] lba;
    logic              ok;
    logic              last_of_request;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              hit;
    logic [4:0]        slot;
    logic [ADDR_W-1:0] sector;
    logic              last;
    logic              request_done;
    logic [5:0]        dirty_count;
    logic [5:0]        high_water;
    logic [31:0]       stall_count;
  } rsp_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SWEEP  = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_RSWEEP = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

endpackage

// ----- rtl/swbc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swbc_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/sector_write_back_cache_tags_unit.sv -----
// Top level of the sector write-back cache tag engine.
// Depends on swbc_pkg and swbc_ram (tag address and tag sequence memories).
//
// Usage:
//   Commands enter on req_i when start is high and busy is low. Each result
//   appears on rsp_o for one cycle with strobe_o high; the receiver cannot
//   hold results off, so no buffering beyond the result register exists.
//   The policy register is written through cfg_we_i / cfg_wdata_i; the user
//   must write it only while idle, which the block itself does not enforce.
// Command flow:
//   Refused writes, invalidate-all, unknown commands and flush-done that is
//   not ok or has no pending run answer in the next cycle and leave the block
//   idle. Write and read lookup sweep the tag memories one slot per cycle.
//   Flush select sweeps twice, walks the run and then emits one result per
//   cycle. Flush done with a run checks the run slots one by one. The sweeps
//   are paced by the single read port of the tag memories.
// Reset:
//   Valid and dirty marks, counters, the pending run and the policy clear at
//   once; the tag memories need no clearing pass.
module sector_write_back_cache_tags_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  swbc_pkg::req_t      req_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  output logic                strobe_o,
  output swbc_pkg::rsp_t      rsp_o
);

  localparam int SW = swbc_pkg::SLOT_W;
  localparam int CW = swbc_pkg::CNT_W;
  localparam int IW = swbc_pkg::RUN_IW;
  localparam int LW = swbc_pkg::RLEN_W;
  localparam int AW = swbc_pkg::ADDR_W;
  localparam int QW = swbc_pkg::SEQ_W;

  swbc_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  swbc_pkg::req_t req_q, req_d;
  logic [swbc_pkg::SLOTS-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [QW-1:0] seq_ctr_q, seq_ctr_d;
  logic [5:0] dtot_q, dtot_d, peak_q, peak_d;
  logic [31:0] stalls_q, stalls_d;
  logic [1:0] policy_q, policy_d;
  logic [LW-1:0] pend_len_q, pend_len_d;
  logic [SW-1:0] pend_slot_q [swbc_pkg::RUN_MAX];
  logic [SW-1:0] pend_slot_d [swbc_pkg::RUN_MAX];
  logic [QW-1:0] pend_seq_q [swbc_pkg::RUN_MAX];
  logic [QW-1:0] pend_seq_d [swbc_pkg::RUN_MAX];
  logic [swbc_pkg::RUN_MAX-1:0] match_q, match_d;
  logic hit_f_q, hit_f_d, free_f_q, free_f_d, cl_f_q, cl_f_d, df_q, df_d;
  logic [SW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, cl_idx_q, cl_idx_d;
  logic [QW-1:0] cl_seq_q, cl_seq_d, d_seq_q, d_seq_d, prev_seq_q, prev_seq_d;
  logic [AW-1:0] d_addr_q, d_addr_d;
  logic [LW-1:0] idx_q, idx_d, run_n_q, run_n_d;
  logic chk_q, chk_d;
  logic [SW-1:0] ps_q, ps_d;
  logic [QW-1:0] pseq_q, pseq_d;
  logic strobe_q, strobe_d;
  swbc_pkg::rsp_t rsp_q, rsp_d;

  logic addr_we, seq_we;
  logic [SW-1:0] waddr, raddr;
  logic [AW-1:0] addr_wdata, rd_addr;
  logic [QW-1:0] seq_wdata, rd_seq;

  logic [CW-1:0] jm;
  logic [SW-1:0] j;
  logic [AW-1:0] diff;
  logic [IW-1:0] k, ik;
  logic [SW-1:0] s;
  logic entry_ok;

  function automatic swbc_pkg::rsp_t mk_rsp(logic [2:0] st, logic h, logic [SW-1:0] sl,
                                            logic [AW-1:0] sec, logic lst, logic rd,
                                            logic [5:0] dc, logic [5:0] hw,
                                            logic [31:0] sc);
    swbc_pkg::rsp_t r;
    r.status       = st;
    r.hit          = h;
    r.slot         = 5'(sl);
    r.sector       = sec;
    r.last         = lst;
    r.request_done = rd;
    r.dirty_count  = dc;
    r.high_water   = hw;
    r.stall_count  = sc;
    return r;
  endfunction

  swbc_ram #(.W(AW), .D(swbc_pkg::SLOTS)) u_addr_ram (
    .clk_i  (clk_i),
    .we_i   (addr_we),
    .waddr_i(waddr),
    .wdata_i(addr_wdata),
    .raddr_i(raddr),
    .rdata_o(rd_addr)
  );

  swbc_ram #(.W(QW), .D(swbc_pkg::SLOTS)) u_seq_ram (
    .clk_i  (clk_i),
    .we_i   (seq_we),
    .waddr_i(waddr),
    .wdata_i(seq_wdata),
    .raddr_i(raddr),
    .rdata_o(rd_seq)
  );

  assign busy     = (state_q != swbc_pkg::ST_IDLE);
  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

  assign jm   = cnt_q - 1'b1;
  assign j    = jm[SW-1:0];
  assign diff = rd_addr - d_addr_q;
  assign k    = diff[IW-1:0];
  assign ik   = idx_q[IW-1:0];

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    req_d      = req_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    seq_ctr_d  = seq_ctr_q;
    dtot_d     = dtot_q;
    peak_d     = peak_q;
    stalls_d   = stalls_q;
    policy_d   = policy_q;
    pend_len_d = pend_len_q;
    pend_slot_d = pend_slot_q;
    pend_seq_d  = pend_seq_q;
    match_d    = match_q;
    hit_f_d    = hit_f_q;
    hit_idx_d  = hit_idx_q;
    free_f_d   = free_f_q;
    free_idx_d = free_idx_q;
    cl_f_d     = cl_f_q;
    cl_idx_d   = cl_idx_q;
    cl_seq_d   = cl_seq_q;
    df_d       = df_q;
    d_seq_d    = d_seq_q;
    d_addr_d   = d_addr_q;
    prev_seq_d = prev_seq_q;
    idx_d      = idx_q;
    run_n_d    = run_n_q;
    chk_d      = chk_q;
    ps_d       = ps_q;
    pseq_d     = pseq_q;
    strobe_d   = 1'b0;
    rsp_d      = rsp_q;
    addr_we    = 1'b0;
    seq_we     = 1'b0;
    waddr      = '0;
    addr_wdata = req_q.lba;
    seq_wdata  = seq_ctr_q + 1'b1;
    raddr      = cnt_q[SW-1:0];
    s          = '0;
    entry_ok   = 1'b0;

    if (cfg_we_i) begin
      policy_d = cfg_wdata_i;
    end

    unique case (state_q)
      swbc_pkg::ST_IDLE: begin
        if (start) begin
          req_d    = req_i;
          cnt_d    = '0;
          hit_f_d  = 1'b0;
          free_f_d = 1'b0;
          cl_f_d   = 1'b0;
          df_d     = 1'b0;
          priority case (req_i.func)
            swbc_pkg::FUNC_WRITE: begin
              if (policy_q[1]) begin
                strobe_d = 1'b1;
                rsp_d = mk_rsp(swbc_pkg::STATUS_REFUSED, 1'b0, '0, '0, 1'b0,
                               req_i.last_of_request, dtot_q, peak_q, stalls_q);
              end else begin
                state_d = swbc_pkg::ST_SWEEP;
              end
            end
            swbc_pkg::FUNC_READ: state_d = swbc_pkg::ST_SWEEP;
            swbc_pkg::FUNC_FLUSH_SEL: begin
              pend_len_d = '0;
              state_d    = swbc_pkg::ST_SWEEP;
            end
            swbc_pkg::FUNC_FLUSH_DONE: begin
              pend_len_d = '0;
              if (req_i.ok && pend_len_q != '0) begin
                run_n_d = pend_len_q;
                idx_d   = '0;
                chk_d   = 1'b0;
                state_d = swbc_pkg::ST_DONE;
              end else begin
                strobe_d = 1'b1;
                rsp_d = mk_rsp(swbc_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0,
                               req_i.last_of_request, dtot_q, peak_q, stalls_q);
              end
            end
            swbc_pkg::FUNC_INVAL_ALL: begin
              valid_d  = '0;
              dirty_d  = '0;
              dtot_d   = '0;
              strobe_d = 1'b1;
              rsp_d = mk_rsp(swbc_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0,
                             req_i.last_of_request, 6'd0, peak_q, stalls_q);
            end
            default: begin
              strobe_d = 1'b1;
              rsp_d = mk_rsp(swbc_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0,
                             req_i.last_of_request, dtot_q, peak_q, stalls_q);
            end
          endcase
        end
      end

      swbc_pkg::ST_SWEEP: begin
        // data of slot cnt-1 is on the RAM outputs
        if (cnt_q != '0) begin
          if (valid_q[j] && rd_addr == req_q.lba && !hit_f_q) begin
            hit_f_d   = 1'b1;
            hit_idx_d = j;
          end
          if (!valid_q[j] && !free_f_q) begin
            free_f_d   = 1'b1;
            free_idx_d = j;
          end
          if (valid_q[j] && !dirty_q[j] && (!cl_f_q || rd_seq < cl_seq_q)) begin
            cl_f_d   = 1'b1;
            cl_idx_d = j;
            cl_seq_d = rd_seq;
          end
          if (dirty_q[j] && (!df_q || rd_seq < d_seq_q)) begin
            df_d     = 1'b1;
            d_seq_d  = rd_seq;
            d_addr_d = rd_addr;
          end
        end
        if (cnt_q == CW'(swbc_pkg::SLOTS)) begin
          state_d = swbc_pkg::ST_DECIDE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      swbc_pkg::ST_DECIDE: begin
        state_d = swbc_pkg::ST_IDLE;
        priority case (req_q.func)
          swbc_pkg::FUNC_READ: begin
            strobe_d = 1'b1;
            rsp_d = mk_rsp(swbc_pkg::STATUS_OK, hit_f_q, hit_f_q ? hit_idx_q : '0, '0,
                           1'b0, req_q.last_of_request, dtot_q, peak_q, stalls_q);
          end
          swbc_pkg::FUNC_FLUSH_SEL: begin
            if (!df_q) begin
              strobe_d = 1'b1;
              rsp_d = mk_rsp(swbc_pkg::STATUS_NODIRTY, 1'b0, '0, '0, 1'b0,
                             req_q.last_of_request, dtot_q, peak_q, stalls_q);
            end else begin
              match_d = '0;
              cnt_d   = '0;
              state_d = swbc_pkg::ST_RSWEEP;
            end
          end
          default: begin
            if (policy_q == swbc_pkg::POLICY_WT) begin
              if (hit_f_q) begin
                valid_d[hit_idx_q] = 1'b0;
                if (dirty_q[hit_idx_q]) begin
                  dirty_d[hit_idx_q] = 1'b0;
                  dtot_d = dtot_q - 1'b1;
                end
              end
              strobe_d = 1'b1;
              rsp_d = mk_rsp(swbc_pkg::STATUS_DIRECT, hit_f_q, hit_f_q ? hit_idx_q : '0,
                             '0, 1'b0, req_q.last_of_request, dtot_d, peak_q, stalls_q);
            end else if (!hit_f_q && !free_f_q && !cl_f_q) begin
              stalls_d = stalls_q + 1'b1;
              strobe_d = 1'b1;
              rsp_d = mk_rsp(swbc_pkg::STATUS_FULL, 1'b0, '0, '0, 1'b0,
                             req_q.last_of_request, dtot_q, peak_q, stalls_d);
            end else begin
              priority if (hit_f_q) s = hit_idx_q;
              else if (free_f_q) s = free_idx_q;
              else s = cl_idx_q;
              seq_ctr_d = seq_ctr_q + 1'b1;
              seq_we    = 1'b1;
              addr_we   = !hit_f_q;
              waddr     = s;
              seq_wdata = seq_ctr_d;
              valid_d[s] = 1'b1;
              if (!dirty_q[s] || !hit_f_q) begin
                // a replaced clean slot always counts as newly dirty
                dirty_d[s] = 1'b1;
                if (!dirty_q[s]) begin
                  dtot_d = dtot_q + 1'b1;
                  if (dtot_d > peak_q) begin
                    peak_d = dtot_d;
                  end
                end
              end
              strobe_d = 1'b1;
              rsp_d = mk_rsp(swbc_pkg::STATUS_OK, hit_f_q, s, '0, 1'b0,
                             req_q.last_of_request, dtot_d, peak_d, stalls_q);
            end
          end
        endcase
      end

      swbc_pkg::ST_RSWEEP: begin
        // first valid slot per run offset, in slot order
        if (cnt_q != '0) begin
          if (valid_q[j] && diff < AW'(swbc_pkg::RUN_MAX) && !match_q[k]) begin
            match_d[k]     = 1'b1;
            pend_slot_d[k] = j;
            pend_seq_d[k]  = rd_seq;
          end
        end
        if (cnt_q == CW'(swbc_pkg::SLOTS)) begin
          idx_d      = '0;
          prev_seq_d = d_seq_q;
          state_d    = swbc_pkg::ST_WALK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      swbc_pkg::ST_WALK: begin
        entry_ok = match_q[ik] && dirty_q[pend_slot_q[ik]] && pend_seq_q[ik] >= prev_seq_q;
        if (entry_ok) begin
          prev_seq_d = pend_seq_q[ik];
          if (idx_q == LW'(swbc_pkg::RUN_MAX - 1)) begin
            run_n_d = LW'(swbc_pkg::RUN_MAX);
            idx_d   = '0;
            state_d = swbc_pkg::ST_EMIT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          run_n_d = idx_q;
          idx_d   = '0;
          state_d = swbc_pkg::ST_EMIT;
        end
      end

      swbc_pkg::ST_EMIT: begin
        strobe_d = 1'b1;
        if (run_n_q == '0) begin
          rsp_d = mk_rsp(swbc_pkg::STATUS_NODIRTY, 1'b0, '0, '0, 1'b0,
                         req_q.last_of_request, dtot_q, peak_q, stalls_q);
          state_d = swbc_pkg::ST_IDLE;
        end else begin
          rsp_d = mk_rsp(swbc_pkg::STATUS_OK, 1'b1, pend_slot_q[ik],
                         d_addr_q + AW'(idx_q), LW'(idx_q + 1'b1) == run_n_q,
                         req_q.last_of_request, dtot_q, peak_q, stalls_q);
          if (LW'(idx_q + 1'b1) == run_n_q) begin
            pend_len_d = run_n_q;
            state_d    = swbc_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      swbc_pkg::ST_DONE: begin
        raddr = pend_slot_q[ik];
        if (chk_q && dirty_q[ps_q] && rd_seq == pseq_q) begin
          dirty_d[ps_q] = 1'b0;
          dtot_d = dtot_q - 1'b1;
        end
        if (idx_q != run_n_q) begin
          ps_d   = pend_slot_q[ik];
          pseq_d = pend_seq_q[ik];
          chk_d  = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          chk_d = 1'b0;
          if (!chk_q) begin
            strobe_d = 1'b1;
            rsp_d = mk_rsp(swbc_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0,
                           req_q.last_of_request, dtot_q, peak_q, stalls_q);
            state_d = swbc_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = swbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= swbc_pkg::ST_IDLE;
      cnt_q      <= '0;
      valid_q    <= '0;
      dirty_q    <= '0;
      seq_ctr_q  <= '0;
      dtot_q     <= '0;
      peak_q     <= '0;
      stalls_q   <= '0;
      policy_q   <= swbc_pkg::POLICY_WB;
      pend_len_q <= '0;
      match_q    <= '0;
      hit_f_q    <= 1'b0;
      free_f_q   <= 1'b0;
      cl_f_q     <= 1'b0;
      df_q       <= 1'b0;
      idx_q      <= '0;
      run_n_q    <= '0;
      chk_q      <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      valid_q    <= valid_d;
      dirty_q    <= dirty_d;
      seq_ctr_q  <= seq_ctr_d;
      dtot_q     <= dtot_d;
      peak_q     <= peak_d;
      stalls_q   <= stalls_d;
      policy_q   <= policy_d;
      pend_len_q <= pend_len_d;
      match_q    <= match_d;
      hit_f_q    <= hit_f_d;
      free_f_q   <= free_f_d;
      cl_f_q     <= cl_f_d;
      df_q       <= df_d;
      idx_q      <= idx_d;
      run_n_q    <= run_n_d;
      chk_q      <= chk_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    pend_slot_q <= pend_slot_d;
    pend_seq_q  <= pend_seq_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    cl_idx_q    <= cl_idx_d;
    cl_seq_q    <= cl_seq_d;
    d_seq_q     <= d_seq_d;
    d_addr_q    <= d_addr_d;
    prev_seq_q  <= prev_seq_d;
    ps_q        <= ps_d;
    pseq_q      <= pseq_d;
    rsp_q       <= rsp_d;
  end

endmodule

// ----- rtl/swbc_checker.sv -----
// Port-level checks for the sector write-back cache tag engine.
// Depends on swbc_pkg; bound to sector_write_back_cache_tags_unit below.
module swbc_port_checks (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           strobe_o,
  input swbc_pkg::rsp_t rsp_o
);

  // an accepted transaction either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> strobe_o || busy)
    else $error("accepted transaction neither answered nor in progress");

  a_nodirty_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && rsp_o.status == swbc_pkg::STATUS_NODIRTY |-> !rsp_o.hit && !rsp_o.last)
    else $error("nothing-dirty result carries a hit");

  a_last_is_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && rsp_o.last |-> rsp_o.hit && rsp_o.status == swbc_pkg::STATUS_OK)
    else $error("run end marker outside a flush run");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> rsp_o.dirty_count <= rsp_o.high_water)
    else $error("dirty count above high water");

endmodule

bind sector_write_back_cache_tags_unit swbc_port_checks u_swbc_port_checks (.*);

// ----- verif/swbc_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sector write-back cache tag engine: watches the command,
// policy and result channels, predicts every result and compares it.
// Depends on swbc_pkg for the transaction types and codes.
module swbc_checker
  import swbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  busy,
  input  req_t  req_i,
  input  logic  cfg_we_i,
  input  logic  [1:0] cfg_wdata_i,
  input  logic  strobe_i,
  input  rsp_t  rsp_i,
  output int    fail_count_o,
  output int    outstanding_o
);

  logic [ADDR_W-1:0] tag_addr [SLOTS];
  logic [SEQ_W-1:0]  tag_seq  [SLOTS];
  logic              valid_q  [SLOTS];
  logic              dirty_q  [SLOTS];
  logic [SEQ_W-1:0]  seq_ctr;
  logic [5:0]        dirty_tot;
  logic [5:0]        dirty_peak;
  logic [31:0]       stall_cnt;
  logic [4:0]        run_slot [RUN_MAX];
  logic [SEQ_W-1:0]  run_seq  [RUN_MAX];
  int                run_len;
  logic [1:0]        policy_q;
  rsp_t              expected_rsp_q[$];

  function automatic int find_slot(logic [ADDR_W-1:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (valid_q[i] && tag_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic void flag_dirty(int s);
    if (!dirty_q[s]) begin
      dirty_q[s] = 1'b1;
      dirty_tot++;
      if (dirty_tot > dirty_peak) dirty_peak = dirty_tot;
    end
  endfunction

  function automatic void flag_clean(int s);
    if (dirty_q[s]) begin
      dirty_q[s] = 1'b0;
      dirty_tot--;
    end
  endfunction

  function automatic void push_rsp(logic [2:0] st, logic hit, int s, logic [31:0] sec,
                                   logic last, logic rd);
    rsp_t r;
    r.status       = st;
    r.hit          = hit;
    r.slot         = 5'(s);
    r.sector       = sec;
    r.last         = last;
    r.request_done = rd;
    r.dirty_count  = dirty_tot;
    r.high_water   = dirty_peak;
    r.stall_count  = stall_cnt;
    expected_rsp_q.push_back(r);
  endfunction

  function automatic void predict_cache_op(req_t r);
    int s;
    int first;
    int n;
    logic [ADDR_W-1:0] base;
    logic [SEQ_W-1:0]  sq;
    logic rd;
    rd = r.last_of_request;
    case (r.func)
      FUNC_WRITE: begin
        if (policy_q >= 2) begin
          push_rsp(STATUS_REFUSED, 0, 0, 0, 0, rd);
          return;
        end
        s = find_slot(r.lba);
        if (policy_q == POLICY_WT) begin
          if (s >= 0) begin
            flag_clean(s);
            valid_q[s] = 1'b0;
          end
          push_rsp(STATUS_DIRECT, s >= 0, (s >= 0) ? s : 0, 0, 0, rd);
          return;
        end
        if (s >= 0) begin
          seq_ctr++;
          tag_seq[s] = seq_ctr;
          flag_dirty(s);
          push_rsp(STATUS_OK, 1, s, 0, 0, rd);
          return;
        end
        for (int i = 0; i < SLOTS && s < 0; i++)
          if (!valid_q[i]) s = i;
        if (s < 0)
          for (int i = 0; i < SLOTS; i++)
            if (valid_q[i] && !dirty_q[i] && (s < 0 || tag_seq[i] < tag_seq[s])) s = i;
        if (s < 0) begin
          stall_cnt++;
          push_rsp(STATUS_FULL, 0, 0, 0, 0, rd);
          return;
        end
        seq_ctr++;
        tag_addr[s] = r.lba;
        tag_seq[s]  = seq_ctr;
        valid_q[s]  = 1'b1;
        dirty_q[s]  = 1'b0;
        flag_dirty(s);
        push_rsp(STATUS_OK, 0, s, 0, 0, rd);
      end
      FUNC_READ: begin
        s = find_slot(r.lba);
        push_rsp(STATUS_OK, s >= 0, (s >= 0) ? s : 0, 0, 0, rd);
      end
      FUNC_FLUSH_SEL: begin
        run_len = 0;
        first = -1;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
          if (dirty_q[i] && (first < 0 || tag_seq[i] < tag_seq[first])) first = i;
        if (first < 0) begin
          push_rsp(STATUS_NODIRTY, 0, 0, 0, 0, rd);
          return;
        end
        base = tag_addr[first];
        sq   = tag_seq[first];
        while (n < RUN_MAX) begin
          s = find_slot(base + 32'(n));
          if (s < 0 || !dirty_q[s] || tag_seq[s] < sq) break;
          sq = tag_seq[s];
          run_slot[n] = 5'(s);
          run_seq[n]  = sq;
          n++;
        end
        run_len = n;
        for (int i = 0; i < n; i++)
          push_rsp(STATUS_OK, 1, run_slot[i], base + 32'(i), i + 1 == n, rd);
      end
      FUNC_FLUSH_DONE: begin
        if (r.ok)
          for (int i = 0; i < run_len; i++)
            if (tag_seq[run_slot[i]] == run_seq[i]) flag_clean(run_slot[i]);
        run_len = 0;
        push_rsp(STATUS_OK, 0, 0, 0, 0, rd);
      end
      FUNC_INVAL_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          flag_clean(i);
          valid_q[i] = 1'b0;
        end
        push_rsp(STATUS_OK, 0, 0, 0, 0, rd);
      end
      default: push_rsp(STATUS_OK, 0, 0, 0, 0, rd);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t w;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid_q[i] = 1'b0;
        dirty_q[i] = 1'b0;
      end
      seq_ctr       = '0;
      dirty_tot     = '0;
      dirty_peak    = '0;
      stall_cnt     = '0;
      run_len       = 0;
      policy_q      = POLICY_WB;
      fail_count_o  = 0;
      expected_rsp_q.delete();
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) policy_q = cfg_wdata_i;
      if (start && !busy) predict_cache_op(req_i);
      if (strobe_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected transaction", rsp_i.status, 0);
        end else begin
          w = expected_rsp_q.pop_front();
          if (rsp_i.status !== w.status) report_mismatch("status", rsp_i.status, w.status);
          if (rsp_i.hit !== w.hit) report_mismatch("hit", rsp_i.hit, w.hit);
          if (rsp_i.slot !== w.slot) report_mismatch("slot", rsp_i.slot, w.slot);
          if (rsp_i.sector !== w.sector) report_mismatch("sector", rsp_i.sector, w.sector);
          if (rsp_i.last !== w.last) report_mismatch("last", rsp_i.last, w.last);
          if (rsp_i.request_done !== w.request_done)
            report_mismatch("request_done", rsp_i.request_done, w.request_done);
          if (rsp_i.dirty_count !== w.dirty_count)
            report_mismatch("dirty_count", rsp_i.dirty_count, w.dirty_count);
          if (rsp_i.high_water !== w.high_water)
            report_mismatch("high_water", rsp_i.high_water, w.high_water);
          if (rsp_i.stall_count !== w.stall_count)
            report_mismatch("stall_count", rsp_i.stall_count, w.stall_count);
        end
      end
      outstanding_o = expected_rsp_q.size();
    end
  end

endmodule

// ----- verif/tb_sector_write_back_cache_tags_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for the sector write-back cache tag engine: drives commands
// and policy writes, gives the verdict. Depends on swbc_pkg and swbc_checker.
module tb_sector_write_back_cache_tags_unit;
  import swbc_pkg::*;

  localparam logic [2:0] FUNC_SPARE    = 3'd5;
  localparam logic [1:0] POLICY_REFUSE = 2'd2;
  localparam logic [1:0] POLICY_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  req_t       req_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic       strobe_o;
  rsp_t       rsp_o;
  int         fail_count;
  int         outstanding;
  int         cycle_count = 0;
  int         sender_idle_pct = 0;
  logic [31:0] lba_base;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sector_write_back_cache_tags_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .strobe_o    (strobe_o),
    .rsp_o       (rsp_o)
  );

  swbc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .strobe_i      (strobe_o),
    .rsp_i         (rsp_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold start low for random gaps, then keep it up until the transaction is taken.
  task automatic issue_cmd(logic [2:0] f, logic [31:0] a, logic ok, logic rd);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{func: f, lba: a, ok: ok, last_of_request: rd};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_policy(logic [1:0] p);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_lba();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return lba_base + 32'($urandom_range(0, 40));
    if (r < 93) return $urandom();
    return (r < 96) ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  task automatic random_cmd();
    int r;
    logic rd;
    rd = 1'($urandom());
    r = $urandom_range(0, 99);
    if (r < 45) issue_cmd(FUNC_WRITE, pick_lba(), 1'($urandom()), rd);
    else if (r < 60) issue_cmd(FUNC_READ, pick_lba(), 1'($urandom()), rd);
    else if (r < 76) issue_cmd(FUNC_FLUSH_SEL, $urandom(), 1'($urandom()), rd);
    else if (r < 93) issue_cmd(FUNC_FLUSH_DONE, $urandom(), $urandom_range(0, 9) != 0, rd);
    else if (r < 96) issue_cmd(FUNC_INVAL_ALL, $urandom(), 1'($urandom()), rd);
    else issue_cmd(3'(FUNC_SPARE + $urandom_range(0, 2)), $urandom(), 1'($urandom()), rd);
  endtask

  initial begin
    logic [1:0] phase_policy [6];
    phase_policy = '{POLICY_WB, POLICY_WT, POLICY_WB, POLICY_REFUSE, POLICY_SPARE, POLICY_WB};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: address extremes, runs, rewrite during a pending run, odd funcs.
    issue_cmd(FUNC_FLUSH_SEL, 32'h0, 1'b0, 1'b1);
    issue_cmd(FUNC_FLUSH_DONE, 32'h0, 1'b1, 1'b0);
    issue_cmd(FUNC_WRITE, 32'h0, 1'b0, 1'b0);
    issue_cmd(FUNC_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue_cmd(FUNC_READ, 32'h0, 1'b0, 1'b1);
    issue_cmd(FUNC_READ, 32'hFFFF_FFFF, 1'b0, 1'b0);
    issue_cmd(FUNC_READ, 32'h1234_5678, 1'b0, 1'b0);
    for (int i = 1; i <= 3; i++) issue_cmd(FUNC_WRITE, 32'(i), 1'b0, 1'b0);
    issue_cmd(FUNC_FLUSH_SEL, 32'h0, 1'b0, 1'b1);
    issue_cmd(FUNC_WRITE, 32'h2, 1'b0, 1'b0);
    issue_cmd(FUNC_FLUSH_DONE, 32'h0, 1'b1, 1'b1);
    issue_cmd(FUNC_FLUSH_SEL, 32'h0, 1'b0, 1'b0);
    issue_cmd(FUNC_FLUSH_SEL, 32'h0, 1'b0, 1'b0);
    issue_cmd(FUNC_FLUSH_DONE, 32'h0, 1'b0, 1'b0);
    issue_cmd(FUNC_SPARE, 32'h0, 1'b1, 1'b1);
    issue_cmd(3'(FUNC_SPARE + 1), 32'hFFFF_FFFF, 1'b0, 1'b0);
    issue_cmd(3'(FUNC_SPARE + 2), 32'h0, 1'b1, 1'b0);
    issue_cmd(FUNC_INVAL_ALL, 32'h0, 1'b0, 1'b1);
    issue_cmd(FUNC_FLUSH_SEL, 32'h0, 1'b0, 1'b0);
    issue_cmd(FUNC_READ, 32'h0, 1'b0, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      write_policy(phase_policy[ph]);
      case (ph % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 71;
        2: sender_idle_pct = 37;
        default: sender_idle_pct = 0;
      endcase
      lba_base = $urandom();
      // Fill every slot with dirty sectors so later writes hit the full case.
      if (ph == 0 || ph == 5)
        for (int i = 0; i < 36; i++)
          issue_cmd(FUNC_WRITE, lba_base + 32'(i), 1'($urandom()), 1'($urandom()));
      for (int i = 0; i < ((ph == 0 || ph == 5) ? 24 : 60); i++) random_cmd();
    end

    drain_results();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
